// ----- src/vmie_pkg.sv -----
// ----------------------------------------------------------------------------
// vmie_pkg
// Shared types and constants for the VM instruction execute block.
// ----------------------------------------------------------------------------
package vmie_pkg;

  typedef enum logic [4:0] {
    FN_MOV  = 5'd0,  FN_ADD  = 5'd1,  FN_SUB  = 5'd2,  FN_MUL  = 5'd3,
    FN_DIV  = 5'd4,  FN_AND  = 5'd5,  FN_OR   = 5'd6,  FN_XOR  = 5'd7,
    FN_SHL  = 5'd8,  FN_SHR  = 5'd9,  FN_SAR  = 5'd10, FN_CMP  = 5'd11,
    FN_JMP  = 5'd12, FN_JZ   = 5'd13, FN_JP   = 5'd14, FN_JN   = 5'd15,
    FN_JNZ  = 5'd16, FN_JNP  = 5'd17, FN_JNN  = 5'd18, FN_JC   = 5'd19,
    FN_JV   = 5'd20, FN_LDH  = 5'd21, FN_LDL  = 5'd22, FN_NOT  = 5'd23,
    FN_SWAP = 5'd24, FN_STOP = 5'd25
  } func_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [1:0] ST_IMM_DEST = 2'd2;

  localparam logic [4:0] REG_IP    = 5'd0;
  localparam logic [4:0] REG_REM   = 5'd16;
  localparam logic [4:0] REG_FLAGS = 5'd17;

  // Flag bit positions inside a 4-bit NZCV nibble
  localparam int unsigned FB_N = 3;
  localparam int unsigned FB_Z = 2;
  localparam int unsigned FB_C = 1;
  localparam int unsigned FB_V = 0;

  // Classified request handed from front to back
  typedef struct packed {
    logic [4:0]  func;
    logic        a_kind;
    logic [4:0]  a_reg;
    logic [31:0] a_val;
    logic        b_kind;
    logic [4:0]  b_reg;
    logic [31:0] b_val;
  } req_t;

  typedef struct packed {
    logic        wr_enable;
    logic [4:0]  wr_index;
    logic [31:0] wr_value;
    logic        wr2_enable;
    logic [4:0]  wr2_index;
    logic [31:0] wr2_value;
    logic [3:0]  flags_nzcv;
    logic [31:0] next_ip;
    logic [1:0]  status;
  } rsp_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_READ, BK_EXEC, BK_MUL, BK_DIV, BK_DONE
  } bk_state_t;

endpackage

// ----- src/vmie_queue.sv -----
// ----------------------------------------------------------------------------
// vmie_queue
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module vmie_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  vmie_pkg::req_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output vmie_pkg::req_t pop_data
);
  import vmie_pkg::*;

  req_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- src/vmie_divider.sv -----
// ----------------------------------------------------------------------------
// vmie_divider
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vmie_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quot,
  output logic [31:0] rem
);
  logic [31:0] q_r, r_r, d_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [32:0] trial;

  assign trial = {r_r, q_r[31]} - {1'b0, d_r};
  assign quot  = q_r;
  assign rem   = r_r;
  assign done  = busy_r && cnt_r == 6'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'd32;
      q_r    <= dividend;
      r_r    <= 32'd0;
      d_r    <= divisor;
    end else if (busy_r) begin
      if (cnt_r == 6'd0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 6'd1;
        if (!trial[32]) begin
          r_r <= trial[31:0];
          q_r <= {q_r[30:0], 1'b1};
        end else begin
          r_r <= {r_r[30:0], q_r[31]};
          q_r <= {q_r[30:0], 1'b0};
        end
      end
    end
  end
endmodule

// ----- src/vmie_front.sv -----
// ----------------------------------------------------------------------------
// vmie_front
// Accepts requests, sign-extends immediates and pushes them into the queue.
// ----------------------------------------------------------------------------
module vmie_front (
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [4:0]     in_func,
  input  logic           in_a_kind,
  input  logic [4:0]     in_a_reg,
  input  logic signed [15:0] in_a_imm,
  input  logic           in_b_kind,
  input  logic [4:0]     in_b_reg,
  input  logic signed [15:0] in_b_imm,
  input  logic           q_full,
  output logic           q_push,
  output vmie_pkg::req_t q_data
);
  import vmie_pkg::*;

  // Operand values are the sign-extended immediates here; register
  // operands are resolved by the back, which owns the register file.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_data.func   = in_func;
    q_data.a_kind = in_a_kind;
    q_data.a_reg  = in_a_reg;
    q_data.a_val  = {{16{in_a_imm[15]}}, in_a_imm};
    q_data.b_kind = in_b_kind;
    q_data.b_reg  = in_b_reg;
    q_data.b_val  = {{16{in_b_imm[15]}}, in_b_imm};
  end
endmodule

// ----- src/vmie_back.sv -----
// ----------------------------------------------------------------------------
// vmie_back
// Register file, ALU, multiply and divide sequencing, result register.
// ----------------------------------------------------------------------------
module vmie_back #(
  parameter int REG_COUNT = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  vmie_pkg::req_t q_data,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output vmie_pkg::rsp_t out_rsp
);
  import vmie_pkg::*;

  logic [31:0] rf_r [REG_COUNT];
  logic [REG_COUNT-1:0] rfv_r;

  bk_state_t   st_r, st_nxt;
  req_t        cur_r;
  logic [31:0] a_r, b_r;
  logic signed [63:0] prod_r;
  rsp_t        rsp_r, rsp_nxt;

  function automatic logic [31:0] rf_rd(input logic [31:0] v, input logic [4:0] i,
                                        input logic ok);
    rf_rd = (ok && 32'(i) < REG_COUNT) ? v : 32'd0;
  endfunction

  logic [31:0] rd_a, rd_b, rd_ip, rd_fl;
  always_comb begin
    rd_a  = (32'(cur_r.a_reg) < REG_COUNT) ? rf_rd(rf_r[cur_r.a_reg[$clog2(REG_COUNT)-1:0]],
             cur_r.a_reg, rfv_r[cur_r.a_reg[$clog2(REG_COUNT)-1:0]]) : 32'd0;
    rd_b  = (32'(cur_r.b_reg) < REG_COUNT) ? rf_rd(rf_r[cur_r.b_reg[$clog2(REG_COUNT)-1:0]],
             cur_r.b_reg, rfv_r[cur_r.b_reg[$clog2(REG_COUNT)-1:0]]) : 32'd0;
    rd_ip = rfv_r[0] ? rf_r[0] : 32'd0;
    rd_fl = rfv_r[REG_FLAGS] ? rf_r[REG_FLAGS] : 32'd0;
  end

  // divider on magnitudes
  logic        dv_start, dv_done;
  logic [31:0] dv_q, dv_m, ma, mb;
  assign ma = a_r[31] ? 32'd0 - a_r : a_r;
  assign mb = b_r[31] ? 32'd0 - b_r : b_r;

  vmie_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(ma), .divisor(mb),
    .done(dv_done), .quot(dv_q), .rem(dv_m)
  );

  // ALU evaluated once a_r/b_r hold the resolved operands
  logic [3:0]  fl_new;
  logic        fl_wr;
  logic [31:0] res;
  logic        dst_wr;
  logic        w2;
  logic [4:0]  i2;
  logic [31:0] v2;
  logic        jw;
  logic [31:0] jv;
  logic [1:0]  stat;
  logic [32:0] sum, dif;
  logic [4:0]  sh;
  logic [31:0] q_s, m_s;
  logic [3:0]  fo;
  logic        take;

  function automatic logic [3:0] nzf(input logic [31:0] r);
    nzf = {r[31], r == 32'd0, 2'b00};
  endfunction

  always_comb begin
    fl_new = 4'd0; fl_wr = 1'b0; res = 32'd0; dst_wr = 1'b0;
    w2 = 1'b0; i2 = 5'd0; v2 = 32'd0; jw = 1'b0; jv = 32'd0; stat = ST_OK;
    sum = {1'b0, a_r} + {1'b0, b_r};
    dif = {1'b0, a_r} - {1'b0, b_r};
    sh  = b_r[4:0];
    q_s = (a_r[31] ^ b_r[31]) ? 32'd0 - dv_q : dv_q;
    m_s = a_r[31] ? 32'd0 - dv_m : dv_m;
    fo  = rd_fl[31:28];
    take = 1'b0;
    unique case (cur_r.func)
      FN_MOV: begin res = b_r; fl_new = nzf(b_r); fl_wr = 1'b1; dst_wr = 1'b1; end
      FN_ADD: begin
        res = sum[31:0]; fl_wr = 1'b1; dst_wr = 1'b1;
        fl_new = nzf(res) | {2'b00, sum[32],
                 (a_r[31] == b_r[31]) && (res[31] != a_r[31])};
      end
      FN_SUB, FN_CMP: begin
        // zero minus the most negative value does not count as overflow
        res = dif[31:0]; fl_wr = 1'b1; dst_wr = cur_r.func == FN_SUB;
        fl_new = nzf(res) | {2'b00, dif[32],
                 (a_r[31] != b_r[31]) && (res[31] != a_r[31]) && (a_r != 32'd0)};
      end
      FN_MUL: begin
        res = prod_r[31:0]; fl_wr = 1'b1; dst_wr = 1'b1;
        fl_new = nzf(res) | {2'b00, {2{prod_r != {{32{res[31]}}, res}}}};
      end
      FN_DIV: begin
        fl_wr = 1'b1;
        if (b_r == 32'd0) begin
          stat = ST_DIV_ZERO;
        end else begin
          res = q_s; dst_wr = 1'b1;
          fl_new = nzf(q_s) | {2'b00, {2{a_r == 32'h8000_0000 && b_r == 32'hFFFF_FFFF}}};
          if (32'(REG_REM) < REG_COUNT) begin w2 = 1'b1; i2 = REG_REM; v2 = m_s; end
        end
      end
      FN_AND: begin res = a_r & b_r; fl_new = nzf(res); fl_wr = 1'b1; dst_wr = 1'b1; end
      FN_OR:  begin res = a_r | b_r; fl_new = nzf(res); fl_wr = 1'b1; dst_wr = 1'b1; end
      FN_XOR: begin res = a_r ^ b_r; fl_new = nzf(res); fl_wr = 1'b1; dst_wr = 1'b1; end
      FN_NOT: begin res = ~a_r;      fl_new = nzf(res); fl_wr = 1'b1; dst_wr = 1'b1; end
      FN_SHL: begin
        fl_wr = 1'b1;
        if (b_r <= 32'd31) begin
          res = a_r << sh; dst_wr = 1'b1;
          fl_new = nzf(res) | {2'b00, (sh != 5'd0) && a_r[5'd0 - sh], 1'b0};
        end
      end
      FN_SHR, FN_SAR: begin
        fl_wr = 1'b1;
        if (b_r <= 32'd31 && !(cur_r.func == FN_SAR && sh == 5'd0)) begin
          res = (cur_r.func == FN_SAR) ? 32'($signed(a_r) >>> sh) : a_r >> sh;
          dst_wr = 1'b1;
          fl_new = nzf(res) | {2'b00, (sh != 5'd0) && a_r[sh - 5'd1], 1'b0};
        end
      end
      FN_LDH: begin res = {a_r[15:0], a_r[15:0]}; dst_wr = 1'b1; end
      FN_LDL: begin res = a_r; dst_wr = 1'b1; end
      FN_SWAP: begin
        res = b_r; dst_wr = 1'b1;
        if (cur_r.b_kind) stat = ST_IMM_DEST;
        else if (32'(cur_r.b_reg) < REG_COUNT) begin
          w2 = 1'b1; i2 = cur_r.b_reg; v2 = a_r;
        end
      end
      FN_STOP: begin jw = 1'b1; jv = 32'hFFFF_FFFF; end
      FN_JMP, FN_JZ, FN_JP, FN_JN, FN_JNZ, FN_JNP, FN_JNN, FN_JC, FN_JV: begin
        unique case (cur_r.func)
          FN_JMP: take = 1'b1;
          FN_JZ:  take = fo[FB_Z];
          FN_JP:  take = !fo[FB_N] && !fo[FB_Z];
          FN_JN:  take = fo[FB_N];
          FN_JNZ: take = !fo[FB_Z];
          FN_JNP: take = fo[FB_N] || fo[FB_Z];
          FN_JNN: take = !fo[FB_N];
          FN_JC:  take = fo[FB_C];
          default: take = fo[FB_V];
        endcase
        jw = take; jv = a_r;
      end
      default: ;
    endcase
    if (dst_wr && cur_r.a_kind) begin
      dst_wr = 1'b0; stat = ST_IMM_DEST;
    end
  end

  // Commit: flags first, then two writes in order. DIV puts the remainder
  // before the quotient; SWAP writes op1 before op2.
  logic        p_en;
  logic [4:0]  p_idx;
  logic [31:0] p_val;
  logic [31:0] ip_f, fl_f;
  logic        swp;
  logic        e1_en, e2_en;
  logic [4:0]  e1_idx, e2_idx;
  logic [31:0] e1_val, e2_val;
  always_comb begin
    p_en  = 1'b0; p_idx = 5'd0; p_val = 32'd0;
    if (jw) begin p_en = 1'b1; p_idx = REG_IP; p_val = jv; end
    else if (dst_wr && 32'(cur_r.a_reg) < REG_COUNT) begin
      p_en = 1'b1; p_idx = cur_r.a_reg; p_val = res;
    end
    swp    = cur_r.func == FN_SWAP;
    e1_en  = swp ? p_en  : w2;
    e1_idx = swp ? p_idx : i2;
    e1_val = swp ? p_val : v2;
    e2_en  = swp ? w2    : p_en;
    e2_idx = swp ? i2    : p_idx;
    e2_val = swp ? v2    : p_val;
    fl_f = fl_wr ? {fl_new, 28'd0} : rd_fl;
    ip_f = rd_ip;
    if (e1_en && e1_idx == REG_FLAGS) fl_f = e1_val;
    if (e1_en && e1_idx == REG_IP)    ip_f = e1_val;
    if (e2_en && e2_idx == REG_FLAGS) fl_f = e2_val;
    if (e2_en && e2_idx == REG_IP)    ip_f = e2_val;
    rsp_nxt.wr_enable  = p_en;  rsp_nxt.wr_index  = p_idx; rsp_nxt.wr_value  = p_val;
    rsp_nxt.wr2_enable = w2;    rsp_nxt.wr2_index = i2;    rsp_nxt.wr2_value = v2;
    rsp_nxt.flags_nzcv = fl_f[31:28];
    rsp_nxt.next_ip    = ip_f;
    rsp_nxt.status     = stat;
  end

  logic exec_now;
  always_comb begin
    st_nxt = st_r; q_pop = 1'b0; dv_start = 1'b0; exec_now = 1'b0;
    unique case (st_r)
      BK_IDLE: if (!q_empty) begin q_pop = 1'b1; st_nxt = BK_READ; end
      BK_READ: st_nxt = BK_EXEC;
      BK_EXEC: begin
        if (cur_r.func == FN_MUL) st_nxt = BK_MUL;
        else if (cur_r.func == FN_DIV && b_r != 32'd0) begin
          dv_start = 1'b1; st_nxt = BK_DIV;
        end
        else begin exec_now = 1'b1; st_nxt = BK_DONE; end
      end
      BK_MUL: begin exec_now = 1'b1; st_nxt = BK_DONE; end
      BK_DIV: if (dv_done) begin exec_now = 1'b1; st_nxt = BK_DONE; end
      BK_DONE: if (!out_stall) begin
        st_nxt = BK_IDLE;
        if (!q_empty) begin q_pop = 1'b1; st_nxt = BK_READ; end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  // READ state latches operands; operand registers hold during execution
  logic in_read;
  assign in_read = st_r == BK_READ;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= BK_IDLE;
      rfv_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (exec_now) begin
        if (fl_wr)  rfv_r[REG_FLAGS] <= 1'b1;
        if (e1_en) rfv_r[e1_idx[$clog2(REG_COUNT)-1:0]] <= 1'b1;
        if (e2_en) rfv_r[e2_idx[$clog2(REG_COUNT)-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_data;
    if (in_read) begin
      a_r <= cur_r.a_kind ? cur_r.a_val : rd_a;
      b_r <= cur_r.b_kind ? cur_r.b_val : rd_b;
    end
    if (st_r == BK_EXEC) prod_r <= $signed(a_r) * $signed(b_r);
    if (exec_now) begin
      rsp_r <= rsp_nxt;
      if (fl_wr)  rf_r[REG_FLAGS] <= {fl_new, 28'd0};
      if (e1_en) rf_r[e1_idx[$clog2(REG_COUNT)-1:0]] <= e1_val;
      if (e2_en) rf_r[e2_idx[$clog2(REG_COUNT)-1:0]] <= e2_val;
    end
  end

  assign out_valid = st_r == BK_DONE;
  assign out_rsp   = rsp_r;
endmodule

// ----- src/vm_instruction_execute.sv -----
// ----------------------------------------------------------------------------
// vm_instruction_execute
// Executes one decoded VM instruction per request against a 32-entry
// register file (IP in r0, remainder in r16, NZCV flags in r17[31:28]).
// ----------------------------------------------------------------------------
// A request is taken by the front into a two-entry queue; the back pops it,
// reads its register operands, executes and holds the result in an output
// register until it is taken. MUL goes through one registered multiply stage;
// DIV runs in the divider, one quotient bit per cycle, while divide by zero
// skips the divider. The back handles one request at a time because each
// instruction may write the registers the next one reads.
// Register indices at or above REG_COUNT read as zero and are never written.
module vm_instruction_execute #(
  parameter int REG_COUNT = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [4:0]         in_func,
  input  logic               in_a_kind,
  input  logic [4:0]         in_a_reg,
  input  logic signed [15:0] in_a_imm,
  input  logic               in_b_kind,
  input  logic [4:0]         in_b_reg,
  input  logic signed [15:0] in_b_imm,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_wr_enable,
  output logic [4:0]         out_wr_index,
  output logic signed [31:0] out_wr_value,
  output logic               out_wr2_enable,
  output logic [4:0]         out_wr2_index,
  output logic signed [31:0] out_wr2_value,
  output logic [3:0]         out_flags_nzcv,
  output logic signed [31:0] out_next_ip,
  output logic [1:0]         out_status
);
  import vmie_pkg::*;

  logic q_full, q_empty, q_push, q_pop;
  req_t q_in, q_out;
  rsp_t rsp;

  vmie_front u_front (
    .in_valid, .in_stall, .in_func, .in_a_kind, .in_a_reg,
    .in_a_imm, .in_b_kind, .in_b_reg, .in_b_imm,
    .q_full, .q_push, .q_data(q_in)
  );

  vmie_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .empty(q_empty), .pop_data(q_out)
  );

  vmie_back #(.REG_COUNT(REG_COUNT)) u_back (
    .clk, .rst_n, .q_empty, .q_data(q_out), .q_pop,
    .out_valid, .out_stall, .out_rsp(rsp)
  );

  assign out_wr_enable  = rsp.wr_enable;
  assign out_wr_index   = rsp.wr_index;
  assign out_wr_value   = rsp.wr_value;
  assign out_wr2_enable = rsp.wr2_enable;
  assign out_wr2_index  = rsp.wr2_index;
  assign out_wr2_value  = rsp.wr2_value;
  assign out_flags_nzcv = rsp.flags_nzcv;
  assign out_next_ip    = rsp.next_ip;
  assign out_status     = rsp.status;
endmodule

// ----- src/vmie_checker.sv -----
// ----------------------------------------------------------------------------
// vmie_checker
// Port-level checks for vm_instruction_execute.
// ----------------------------------------------------------------------------
module vmie_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_wr_enable,
  input logic [4:0]  out_wr_index,
  input logic [31:0] out_wr_value,
  input logic        out_wr2_enable,
  input logic [1:0]  out_status
);
  import vmie_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_wr_value))
    else $error("result changed under stall");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_IMM_DEST)
    else $error("bad status");
  a_dz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_DIV_ZERO |-> !out_wr_enable && !out_wr2_enable)
    else $error("write on divide by zero");
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_wr_enable |-> out_wr_index == 5'd0 && out_wr_value == 32'd0)
    else $error("disabled write not zero");
endmodule

bind vm_instruction_execute vmie_checker u_chk (
  .clk, .rst_n, .out_valid, .out_stall, .out_wr_enable, .out_wr_index,
  .out_wr_value, .out_wr2_enable, .out_status
);

// ----- test/tb_vm_instruction_execute.sv -----
// ----------------------------------------------------------------------------
// tb_vm_instruction_execute
// Self-checking bench: directed and random instructions through the execute
// stage, checked against a behavioral register-file model under random idling and output stalls.
// ----------------------------------------------------------------------------
module tb_vm_instruction_execute;
  import vmie_pkg::*;

  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [4:0] in_func = '0;
  logic in_a_kind = 1'b0;
  logic [4:0] in_a_reg = '0;
  logic signed [15:0] in_a_imm = '0;
  logic in_b_kind = 1'b0;
  logic [4:0] in_b_reg = '0;
  logic signed [15:0] in_b_imm = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_wr_enable;
  logic [4:0] out_wr_index;
  logic signed [31:0] out_wr_value;
  logic out_wr2_enable;
  logic [4:0] out_wr2_index;
  logic signed [31:0] out_wr2_value;
  logic [3:0] out_flags_nzcv;
  logic signed [31:0] out_next_ip;
  logic [1:0] out_status;

  vm_instruction_execute dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  logic [31:0] regs [32];
  rsp_t exp_q [$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_off = 0;

  // ---- behavioral execute model -------------------------------------------
  function automatic logic [31:0] opnd(logic k, logic [4:0] r, logic [15:0] imm);
    return k ? {{16{imm[15]}}, imm} : regs[r];
  endfunction

  function automatic logic [3:0] nzf(logic [31:0] r);
    return {r[31], r == 0, 2'b00};
  endfunction

  function automatic rsp_t execute(logic [4:0] fn, logic ak, logic [4:0] ar,
                                   logic [15:0] ai, logic bk, logic [4:0] br,
                                   logic [15:0] bi);
    rsp_t o;
    logic [31:0] a, b, r, ma, mb, q, m;
    logic [3:0] f, fl;
    logic signed [63:0] p;
    logic [32:0] s;
    bit dest, take;
    o = '0;
    a = opnd(ak, ar, ai);
    b = opnd(bk, br, bi);
    r = 0; f = 0; dest = 0; take = 0;
    case (fn)
      FN_MOV: begin r = b; regs[REG_FLAGS] = {nzf(b), 28'd0}; dest = 1; end
      FN_ADD: begin
        r = a + b; f = nzf(r);
        f[FB_V] = (a[31] == b[31]) && (r[31] != a[31]);
        f[FB_C] = r < a;
        regs[REG_FLAGS] = {f, 28'd0}; dest = 1;
      end
      FN_SUB, FN_CMP: begin
        r = a - b; f = nzf(r);
        f[FB_V] = (a[31] != b[31]) && (r[31] != a[31]) && (a != 0);
        f[FB_C] = a < b;
        regs[REG_FLAGS] = {f, 28'd0}; dest = (fn == FN_SUB);
      end
      FN_MUL: begin
        p = $signed(a) * $signed(b); r = p[31:0]; f = nzf(r);
        if (p != {{32{r[31]}}, r}) f[1:0] = 2'b11;
        regs[REG_FLAGS] = {f, 28'd0}; dest = 1;
      end
      FN_DIV: begin
        if (b == 0) begin
          regs[REG_FLAGS] = 0; o.status = ST_DIV_ZERO;
        end else begin
          ma = a[31] ? -a : a; mb = b[31] ? -b : b;
          q = ma / mb; m = ma % mb;
          if (a[31] ^ b[31]) q = -q;
          if (a[31]) m = -m;
          f = nzf(q);
          if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) f[1:0] = 2'b11;
          regs[REG_FLAGS] = {f, 28'd0};
          regs[REG_REM] = m;
          o.wr2_enable = 1; o.wr2_index = REG_REM; o.wr2_value = m;
          r = q; dest = 1;
        end
      end
      FN_AND, FN_OR, FN_XOR, FN_NOT: begin
        r = fn == FN_AND ? a & b : fn == FN_OR ? a | b : fn == FN_XOR ? a ^ b : ~a;
        regs[REG_FLAGS] = {nzf(r), 28'd0}; dest = 1;
      end
      FN_SHL: begin
        if (b > 31) regs[REG_FLAGS] = 0;
        else begin
          s = {1'b0, a} << b; r = s[31:0];
          f = nzf(r); f[FB_C] = (b > 0) && s[32];
          regs[REG_FLAGS] = {f, 28'd0}; dest = 1;
        end
      end
      FN_SHR, FN_SAR: begin
        if (b > 31 || (fn == FN_SAR && b == 0)) regs[REG_FLAGS] = 0;
        else begin
          r = fn == FN_SAR ? $unsigned($signed(a) >>> b) : a >> b;
          f = nzf(r); f[FB_C] = (b > 0) && a[b - 1];
          regs[REG_FLAGS] = {f, 28'd0}; dest = 1;
        end
      end
      FN_LDH: begin r = {a[15:0], a[15:0]}; dest = 1; end
      FN_LDL: begin r = a; dest = 1; end
      FN_SWAP: begin
        if (ak) o.status = ST_IMM_DEST;
        else begin regs[ar] = b; o.wr_enable = 1; o.wr_index = ar; o.wr_value = b; end
        if (bk) o.status = ST_IMM_DEST;
        else begin regs[br] = a; o.wr2_enable = 1; o.wr2_index = br; o.wr2_value = a; end
      end
      FN_STOP: begin
        regs[REG_IP] = '1; o.wr_enable = 1; o.wr_index = REG_IP; o.wr_value = '1;
      end
      default: if (fn >= FN_JMP && fn <= FN_JV) begin
        fl = regs[REG_FLAGS][31:28];
        case (fn)
          FN_JMP: take = 1;
          FN_JZ:  take = fl[FB_Z];
          FN_JP:  take = !fl[FB_N] && !fl[FB_Z];
          FN_JN:  take = fl[FB_N];
          FN_JNZ: take = !fl[FB_Z];
          FN_JNP: take = fl[FB_N] || fl[FB_Z];
          FN_JNN: take = !fl[FB_N];
          FN_JC:  take = fl[FB_C];
          default: take = fl[FB_V];
        endcase
        if (take) begin
          regs[REG_IP] = a; o.wr_enable = 1; o.wr_index = REG_IP; o.wr_value = a;
        end
      end
    endcase
    if (dest) begin
      if (ak) o.status = ST_IMM_DEST;
      else begin regs[ar] = r; o.wr_enable = 1; o.wr_index = ar; o.wr_value = r; end
    end
    o.flags_nzcv = regs[REG_FLAGS][31:28];
    o.next_ip = regs[REG_IP];
    return o;
  endfunction

  // ---- request driver -----------------------------------------------------
  task automatic send_request(logic [4:0] fn, logic ak, logic [4:0] ar,
                              logic [15:0] ai, logic bk, logic [4:0] br,
                              logic [15:0] bi);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= fn; in_a_kind <= ak; in_a_reg <= ar; in_a_imm <= ai;
    in_b_kind <= bk; in_b_reg <= br; in_b_imm <= bi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp_q.push_back(execute(fn, ak, ar, ai, bk, br, bi));
    n_sent++;
  endtask

  task automatic end_burst;
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---- receiver stall and result checker ----------------------------------
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= stall_pct > 0 && $urandom_range(99) < stall_pct;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch result %0d: %s got %h want %h", n_checked, what, got, want);
  endtask

  always @(posedge clk) begin
    rsp_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_q.size() == 0) begin
        report_mismatch("unexpected result", 32'd1, 32'd0);
      end else begin
        e = exp_q.pop_front();
        if (out_wr_enable !== e.wr_enable) report_mismatch("wr_enable", out_wr_enable, e.wr_enable);
        if (out_wr_index !== e.wr_index) report_mismatch("wr_index", out_wr_index, e.wr_index);
        if (out_wr_value !== e.wr_value) report_mismatch("wr_value", out_wr_value, e.wr_value);
        if (out_wr2_enable !== e.wr2_enable)
          report_mismatch("wr2_enable", out_wr2_enable, e.wr2_enable);
        if (out_wr2_index !== e.wr2_index) report_mismatch("wr2_index", out_wr2_index, e.wr2_index);
        if (out_wr2_value !== e.wr2_value) report_mismatch("wr2_value", out_wr2_value, e.wr2_value);
        if (out_flags_nzcv !== e.flags_nzcv) report_mismatch("flags", out_flags_nzcv, e.flags_nzcv);
        if (out_next_ip !== e.next_ip) report_mismatch("next_ip", out_next_ip, e.next_ip);
        if (out_status !== e.status) report_mismatch("status", out_status, e.status);
        n_checked++;
      end
    end
  end

  // watchdog: cycles with no request or result moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else if (rst_n) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog timeout, %0d results outstanding", exp_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---- tests --------------------------------------------------------------
  // Values that hit the edges: zero, +-1, sign bit, all ones, shift limits.
  function automatic logic [15:0] edge_imm();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'hFFFF;
      3: return 16'h8000;
      4: return 16'h7FFF;
      5: return 16'd31;
      6: return 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed;
    // every operation once, register dest, random regs
    for (int fn = 0; fn <= 25; fn++)
      send_request(5'(fn), 0, 5'($urandom_range(1, 20)), 0, 1, 0, edge_imm());
    // DIV overflow: INT_MIN into r5, then r5 / -1
    send_request(FN_MOV, 0, 5, 0, 1, 0, 16'h8000);
    send_request(FN_LDL, 0, 5, 0, 0, 0, 0);
    send_request(FN_SHL, 0, 5, 0, 1, 0, 16'd16);
    send_request(FN_DIV, 0, 5, 0, 1, 0, 16'hFFFF);
    // divide by zero, immediate destination, SWAP with an immediate first operand
    send_request(FN_DIV, 0, 3, 0, 1, 0, 16'h0000);
    send_request(FN_ADD, 1, 0, 16'h7FFF, 1, 0, 16'h7FFF);
    send_request(FN_SWAP, 1, 0, 16'h1234, 0, 7, 0);
    // DIV into r16 keeps quotient; MOV into r17 overwrites flags
    send_request(FN_DIV, 0, 16, 0, 1, 0, 16'd7);
    send_request(FN_MOV, 0, 17, 0, 1, 0, 16'hA000);
    // shift counts out of range
    send_request(FN_SAR, 0, 4, 0, 1, 0, 16'd0);
    send_request(FN_SHR, 0, 4, 0, 1, 0, 16'hFFFF);
    end_burst();
  endtask

  function automatic logic [4:0] rand_func();
    // weight DIV down: it is slow in hardware
    logic [4:0] f;
    f = 5'($urandom_range(31));
    if (f == FN_DIV && $urandom_range(3) != 0) f = FN_ADD;
    return f;
  endfunction

  task automatic test_random(int count);
    logic [15:0] bi;
    for (int i = 0; i < count; i++) begin
      bi = $urandom_range(1) ? edge_imm() : 16'($urandom);
      send_request(rand_func(), $urandom_range(9) == 0, 5'($urandom),
                   16'($urandom), 1'($urandom_range(1)), 5'($urandom), bi);
    end
    end_burst();
  endtask

  task automatic drain;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic test_backpressure;
    // receiver holds off long enough for the input queue to fill
    fork
      begin
        hold_off = 1;
        repeat (200) @(posedge clk);
        hold_off = 0;
      end
      test_random(40);
    join
  endtask

  initial begin
    foreach (regs[i]) regs[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    drain();
    test_random(400);
    send_idle_pct = 47;
    test_random(400);
    send_idle_pct = 0; stall_pct = 47;
    test_random(400);
    send_idle_pct = 17; stall_pct = 17;
    test_random(400);
    send_idle_pct = 0; stall_pct = 0;
    test_backpressure();
    drain();

    $display("covered %0d requests, %0d results checked: all ops, edge values,",
             n_sent, n_checked);
    $display("div by zero/overflow, immediate dests, idle and backpressure phases");
    if (errors == 0 && exp_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, exp_q.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/vmie_pkg.sv
src/vmie_queue.sv
src/vmie_divider.sv
src/vmie_front.sv
src/vmie_back.sv
src/vm_instruction_execute.sv
src/vmie_checker.sv
test/tb_vm_instruction_execute.sv
